[rtl/core/rgbnf_pkg.sv]
// Package for the RGB 3x3 neighborhood filter.
// Holds the pixel and beat types, configuration register codes and filter modes.
// No dependencies.
`default_nettype none

package rgbnf_pkg;

  // Widths fixed by the register map and the pixel format.
  localparam int unsigned CHAN_W      = 8;
  localparam int unsigned MODE_W      = 3;
  localparam int unsigned IMG_W       = 12;
  localparam int unsigned CFG_INDEX_W = 1;
  localparam int unsigned CFG_DATA_W  = 12;
  localparam int unsigned TAPS        = 9;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_FILTER_MODE = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH = 1'd1;

  // Reset values of the configuration registers.
  localparam logic [MODE_W-1:0] FILTER_MODE_RESET = 3'd0;
  localparam logic [IMG_W-1:0]  IMAGE_WIDTH_RESET = 12'd2048;

  // Filter modes; the two unused codes behave as copy.
  typedef enum logic [MODE_W-1:0] {
    MODE_COPY    = 3'd0,
    MODE_AVERAGE = 3'd1,
    MODE_SHARPEN = 3'd2,
    MODE_EDGE    = 3'd3,
    MODE_EMBOSS  = 3'd4,
    MODE_MAXIMUM = 3'd5
  } filter_mode_t;

  // One stored pixel.
  typedef struct packed {
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] red;
  } rgb_t;

  // Input beat.
  typedef struct packed {
    logic [CHAN_W-1:0] red_in;
    logic [CHAN_W-1:0] green_in;
    logic [CHAN_W-1:0] blue_in;
    logic              is_pad;
  } in_beat_t;

  // Output beat.
  typedef struct packed {
    logic [CHAN_W-1:0] red_out;
    logic [CHAN_W-1:0] green_out;
    logic [CHAN_W-1:0] blue_out;
    logic              frame_last;
  } out_beat_t;

  // The nine samples of one channel, row-major: index = row * 3 + column.
  typedef logic [TAPS-1:0][CHAN_W-1:0] taps_t;

endpackage

`default_nettype wire

[rtl/core/rgbnf_stream_if.sv]
// Valid/ready stream interface used by the filter's pixel channels.
// The payload type is a parameter; no other dependencies.
`default_nettype none

interface rgbnf_stream_if #(
  parameter type payload_t = logic
);

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);

endinterface

`default_nettype wire

[rtl/core/rgb_3x3_neighborhood_filter.sv]
// RGB 3x3 neighborhood filter over a raster pixel stream, with two line stores.
// Uses rgbnf_pkg, rgbnf_stream_if and rgbnf_chan_filter.
//
// Usage:
//   pixel_in carries one RGB pixel per beat in raster order; pixel_out carries
//   one filtered pixel per beat. The result for a pixel appears once its whole
//   3x3 neighborhood has arrived, i.e. image_width+1 input beats later; pixels
//   outside the image count as zero. After the last row the source sends
//   image_width+1 beats with is_pad set; the last of them brings the frame's
//   final result, marked with frame_last.
//   The block takes one pixel per clock while pixel_in.ready is high. Once a
//   beat is accepted, its result (if it causes one) passes the registered
//   line store read, then the window and kernel stage, then the output register.
//   A stalled receiver holds the output register; input is still taken while
//   the two inner stages have room, then pixel_in.ready drops.
//   The configuration port (cfg_we, cfg_index, cfg_data) writes filter_mode
//   and image_width; write them only while no result is outstanding.
//   After reset the line stores are cleared one entry per clock across all
//   MAX_WIDTH entries, and pixel_in.ready stays low until that pass is done.
`default_nettype none

module rgb_3x3_neighborhood_filter #(
  parameter int unsigned MAX_WIDTH = 2048
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [rgbnf_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [rgbnf_pkg::CFG_DATA_W-1:0]     cfg_data,
  rgbnf_stream_if.sink                         pixel_in,
  rgbnf_stream_if.source                       pixel_out
);
  import rgbnf_pkg::*;

  localparam int unsigned AW = $clog2(MAX_WIDTH);
  localparam int unsigned WW = AW + 1;
  localparam int unsigned CW = (WW > IMG_W) ? WW : IMG_W;

  // Configuration registers.
  logic [MODE_W-1:0] filter_mode;
  logic [IMG_W-1:0]  image_width;

  // Stream position state.
  logic [AW-1:0] column_count;
  logic [1:0]    row_phase;
  logic [WW-1:0] pad_count;

  // Clearing pass.
  logic          clr_active;
  logic [AW-1:0] clr_addr;

  // Line stores and their registered read data.
  rgb_t line_upper [MAX_WIDTH];
  rgb_t line_lower [MAX_WIDTH];
  rgb_t upper_q;
  rgb_t lower_q;

  // Read stage registers.
  typedef struct packed {
    logic valid;
    logic use_up;
    logic use_lo;
    logic fwd;
    logic emit;
    logic last;
    logic lz;
    logic rz;
  } s1_ctl_t;

  s1_ctl_t       s1;
  logic [AW-1:0] s1_addr;
  rgb_t          s1_pix;
  rgb_t          s1_fwd_upper;
  rgb_t          s1_fwd_lower;

  // Window stage registers.
  logic s2_valid;
  logic s2_emit;
  logic s2_last;
  logic s2_lz;
  logic s2_rz;
  rgb_t win [3][3];

  // Output register.
  logic      out_valid;
  out_beat_t out_data;

  // Handshake and stage flow.
  logic out_free;
  logic s2_free;
  logic s1_free;
  logic accept;
  logic s1_move;

  // Accept-side decode.
  logic [CW-1:0] w_ext;
  logic [CW-1:0] max_ext;
  logic [CW-1:0] w_cl;
  logic [WW-1:0] w_eff;
  logic [WW-1:0] col_ext;
  logic [WW-1:0] j_ext;
  logic [WW-1:0] j_inc;
  logic [AW-1:0] j;
  logic [WW-1:0] pad_inc;
  logic          pad;
  logic          row_end;
  logic          flush_end;
  rgb_t          pix;

  logic [AW-1:0] column_count_next;
  logic [1:0]    row_phase_next;
  logic [WW-1:0] pad_count_next;

  // Read stage values after gating and forwarding.
  rgb_t up_eff;
  rgb_t lo_eff;

  // Memory write port.
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  rgb_t          mem_wupper;
  rgb_t          mem_wlower;

  // Kernel inputs and outputs.
  taps_t             taps_r;
  taps_t             taps_g;
  taps_t             taps_b;
  logic [CHAN_W-1:0] res_r;
  logic [CHAN_W-1:0] res_g;
  logic [CHAN_W-1:0] res_b;

  // Stage flow: a stage moves on when the one after it can take its beat.
  assign out_free       = !out_valid || pixel_out.ready;
  assign s2_free        = !s2_valid || !s2_emit || out_free;
  assign s1_free        = !s1.valid || s2_free;
  assign pixel_in.ready = s1_free && !clr_active;
  assign accept         = pixel_in.valid && pixel_in.ready;
  assign s1_move        = s1.valid && s2_free;

  // Clamp the width and locate the incoming beat in the frame.
  always_comb begin
    w_ext   = CW'(image_width);
    max_ext = CW'(MAX_WIDTH);
    if (w_ext == '0) begin
      w_cl = CW'(1);
    end else if (w_ext > max_ext) begin
      w_cl = max_ext;
    end else begin
      w_cl = w_ext;
    end
    w_eff   = WW'(w_cl);
    col_ext = {1'b0, column_count};
    j_ext   = (col_ext >= w_eff) ? '0 : col_ext;
    j       = j_ext[AW-1:0];
    j_inc   = j_ext + WW'(1);
    row_end = (j_inc >= w_eff);
    pad     = pixel_in.data.is_pad || (pad_count != '0);
    pad_inc = pad_count + WW'(1);
    flush_end = ({1'b0, pad_inc} >= ({1'b0, w_eff} + (WW + 1)'(1)));
    pix.red   = pad ? '0 : pixel_in.data.red_in;
    pix.green = pad ? '0 : pixel_in.data.green_in;
    pix.blue  = pad ? '0 : pixel_in.data.blue_in;
  end

  // Next column, row phase and pad count.
  always_comb begin
    column_count_next = row_end ? '0 : j_inc[AW-1:0];
    row_phase_next    = (row_end && row_phase < 2'd2) ? row_phase + 2'd1 : row_phase;
    pad_count_next    = pad_count;
    if (pad) begin
      pad_count_next = pad_inc;
      if (flush_end) begin
        column_count_next = '0;
        row_phase_next    = 2'd0;
        pad_count_next    = '0;
      end
    end
  end

  // Configuration writes, stream position and clearing pass.
  always_ff @(posedge clk) begin
    if (rst) begin
      filter_mode  <= FILTER_MODE_RESET;
      image_width  <= IMAGE_WIDTH_RESET;
      column_count <= '0;
      row_phase    <= 2'd0;
      pad_count    <= '0;
      clr_active   <= 1'b1;
      clr_addr     <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_FILTER_MODE: filter_mode <= cfg_data[MODE_W-1:0];
          CFG_IMAGE_WIDTH: image_width <= cfg_data[IMG_W-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        column_count <= column_count_next;
        row_phase    <= row_phase_next;
        pad_count    <= pad_count_next;
      end
      if (clr_active) begin
        if (clr_addr == AW'(MAX_WIDTH - 1)) begin
          clr_active <= 1'b0;
        end
        clr_addr <= clr_addr + AW'(1);
      end
    end
  end

  // Read stage: gate the stored rows and take the value written at this
  // address on the previous beat when it has not reached the store yet.
  always_comb begin
    up_eff = '0;
    lo_eff = '0;
    if (s1.use_up) begin
      up_eff = s1.fwd ? s1_fwd_upper : upper_q;
    end
    if (s1.use_lo) begin
      lo_eff = s1.fwd ? s1_fwd_lower : lower_q;
    end
  end

  // Line store write port: clearing pass, or the beat leaving the read stage.
  always_comb begin
    mem_we     = clr_active || s1_move;
    mem_waddr  = clr_active ? clr_addr : s1_addr;
    mem_wupper = clr_active ? '0 : lo_eff;
    mem_wlower = clr_active ? '0 : s1_pix;
  end

  // Line stores.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      line_upper[mem_waddr] <= mem_wupper;
      line_lower[mem_waddr] <= mem_wlower;
    end
    if (accept) begin
      upper_q <= line_upper[j];
      lower_q <= line_lower[j];
    end
  end

  // Read stage registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1 <= '0;
    end else begin
      if (accept) begin
        s1.valid  <= 1'b1;
        s1.use_up <= (row_phase >= 2'd2);
        s1.use_lo <= (row_phase >= 2'd1);
        s1.fwd    <= s1_move && (s1_addr == j);
        s1.emit   <= (row_phase >= 2'd2) || (row_phase == 2'd1 && j_ext >= WW'(1));
        s1.last   <= pad && flush_end;
        s1.lz     <= (j_ext == WW'(1)) || (w_eff == WW'(1));
        s1.rz     <= (j_ext == '0);
      end else if (s1_move) begin
        s1.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_addr      <= j;
      s1_pix       <= pix;
      s1_fwd_upper <= lo_eff;
      s1_fwd_lower <= s1_pix;
    end
  end

  // Window stage: shift the 3x3 window by one column per beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      s2_emit  <= 1'b0;
      s2_last  <= 1'b0;
      s2_lz    <= 1'b0;
      s2_rz    <= 1'b0;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win[r][c] <= '0;
        end
      end
    end else if (s2_free) begin
      s2_valid <= s1.valid;
      if (s1.valid) begin
        s2_emit <= s1.emit;
        s2_last <= s1.last;
        s2_lz   <= s1.lz;
        s2_rz   <= s1.rz;
        for (int r = 0; r < 3; r++) begin
          win[r][0] <= win[r][1];
          win[r][1] <= win[r][2];
        end
        win[0][2] <= up_eff;
        win[1][2] <= lo_eff;
        win[2][2] <= s1_pix;
      end
    end
  end

  // Neighborhood taps with the columns outside the image forced to zero.
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if ((c == 0 && s2_lz) || (c == 2 && s2_rz)) begin
          taps_r[r * 3 + c] = '0;
          taps_g[r * 3 + c] = '0;
          taps_b[r * 3 + c] = '0;
        end else begin
          taps_r[r * 3 + c] = win[r][c].red;
          taps_g[r * 3 + c] = win[r][c].green;
          taps_b[r * 3 + c] = win[r][c].blue;
        end
      end
    end
  end

  rgbnf_chan_filter u_filt_red (
    .mode   (filter_mode),
    .taps   (taps_r),
    .result (res_r)
  );

  rgbnf_chan_filter u_filt_green (
    .mode   (filter_mode),
    .taps   (taps_g),
    .result (res_g)
  );

  rgbnf_chan_filter u_filt_blue (
    .mode   (filter_mode),
    .taps   (taps_b),
    .result (res_b)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_valid && s2_emit && out_free) begin
      out_valid <= 1'b1;
    end else if (pixel_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_valid && s2_emit && out_free) begin
      out_data.red_out    <= res_r;
      out_data.green_out  <= res_g;
      out_data.blue_out   <= res_b;
      out_data.frame_last <= s2_last;
    end
  end

  assign pixel_out.valid = out_valid;
  assign pixel_out.data  = out_data;

endmodule

`default_nettype wire

[rtl/core/rgbnf_chan_filter.sv]
// Per-channel 3x3 kernel: copy, average, sharpen, edge, emboss or maximum.
// Combinational; uses rgbnf_pkg for the tap type and the mode codes.
`default_nettype none

module rgbnf_chan_filter (
  input  logic [rgbnf_pkg::MODE_W-1:0] mode,
  input  rgbnf_pkg::taps_t             taps,
  output logic [rgbnf_pkg::CHAN_W-1:0] result
);
  import rgbnf_pkg::*;

  localparam int unsigned SUM_W = 13;

  logic signed [SUM_W-1:0] t [TAPS];
  logic signed [SUM_W-1:0] s_avg;
  logic signed [SUM_W-1:0] s_sharp;
  logic signed [SUM_W-1:0] s_edge;
  logic signed [SUM_W-1:0] s_emb;
  logic signed [SUM_W-1:0] s_sel;
  logic [CHAN_W-1:0]       best;
  logic                    use_sum;

  // Zero-extend the samples into signed sum width.
  always_comb begin
    for (int i = 0; i < TAPS; i++) begin
      t[i] = $signed({{(SUM_W - CHAN_W){1'b0}}, taps[i]});
    end
  end

  // Kernel sums written as shifts and adds.
  always_comb begin
    s_avg   = t[0] + (t[1] <<< 1) + t[2] + (t[3] <<< 1) + (t[4] <<< 2)
            + (t[5] <<< 1) + t[6] + (t[7] <<< 1) + t[8];
    s_sharp = (t[4] <<< 2) + t[4] - t[1] - t[3] - t[5] - t[7];
    s_edge  = (t[4] <<< 3) - t[0] - t[1] - t[2] - t[3] - t[5] - t[6] - t[7] - t[8];
    s_emb   = t[4] + t[5] + t[7] + (t[8] <<< 1) - (t[0] <<< 1) - t[1] - t[3];
  end

  // Running maximum over the neighborhood.
  always_comb begin
    best = '0;
    for (int i = 0; i < TAPS; i++) begin
      if (taps[i] > best) begin
        best = taps[i];
      end
    end
  end

  // Select by mode. The average sum is never negative, so the shift truncates.
  always_comb begin
    use_sum = 1'b1;
    s_sel   = '0;
    case (mode)
      MODE_AVERAGE: s_sel = s_avg >>> 4;
      MODE_SHARPEN: s_sel = s_sharp;
      MODE_EDGE:    s_sel = s_edge;
      MODE_EMBOSS:  s_sel = s_emb;
      default:      use_sum = 1'b0;
    endcase
  end

  // Saturate to the channel range, or pass the maximum or the center through.
  always_comb begin
    if (!use_sum) begin
      result = (mode == MODE_MAXIMUM) ? best : taps[4];
    end else if (s_sel < 0) begin
      result = '0;
    end else if (s_sel > $signed(SUM_W'(255))) begin
      result = '1;
    end else begin
      result = s_sel[CHAN_W-1:0];
    end
  end

endmodule

`default_nettype wire
